// ===== rtl/irlcf_pkg.sv =====
// ----------------------------------------------------------------------------
// IR light command framer package
// Shared types, frame constants and the 6-bit to 8-bit symbol code table.
// ----------------------------------------------------------------------------
package irlcf_pkg;

  localparam int unsigned FRAME_QUEUE_DEPTH = 2;
  localparam int unsigned FRAME_BYTES       = 8;

  // Fixed mode codes of a motion command.
  localparam logic [5:0] MOTION_MODE0   = 6'h23;
  localparam logic [5:0] MOTION_MODE1   = 6'h30;
  localparam logic [2:0] MOTION_ATK_LOW = 3'b111;

  // Result index of the final byte for a short and a long frame.
  localparam logic [3:0] SHORT_LAST_IDX = 4'd5;
  localparam logic [3:0] LONG_LAST_IDX  = 4'd8;

  localparam logic [7:0] CODE_MAP [64] = '{
    8'h21, 8'h32, 8'h54, 8'h65, 8'ha9, 8'h9a, 8'h6d, 8'h29,
    8'h56, 8'h92, 8'ha1, 8'hb4, 8'hb2, 8'h84, 8'h66, 8'h2a,
    8'h4c, 8'h6a, 8'ha6, 8'h95, 8'h62, 8'h51, 8'h42, 8'h24,
    8'h35, 8'h46, 8'h8a, 8'hac, 8'h8c, 8'h6c, 8'h2c, 8'h4a,
    8'h59, 8'h86, 8'ha4, 8'ha2, 8'h91, 8'h64, 8'h55, 8'h44,
    8'h22, 8'h31, 8'hb1, 8'h52, 8'h85, 8'h96, 8'ha5, 8'h69,
    8'h5a, 8'h2d, 8'h4d, 8'h89, 8'h45, 8'h34, 8'h61, 8'h25,
    8'h36, 8'had, 8'h94, 8'haa, 8'h8d, 8'h49, 8'h99, 8'h26
  };

  // One classified command: byte 0 is the checksum, unused bytes are zero.
  typedef struct packed {
    logic                              rejected;
    logic                              long_frm;
    logic [FRAME_BYTES-1:0][7:0]       sym;
  } frame_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       is_preamble;
    logic       rejected;
    logic       last;
  } res_t;

  function automatic logic [7:0] enc(input logic [5:0] v);
    return CODE_MAP[v];
  endfunction

endpackage

// ===== rtl/irlcf_front.sv =====
// ----------------------------------------------------------------------------
// IR light command framer front end
// Accepts commands, checks the colour range, encodes payload bytes and
// forms the checksum before handing the frame to the queue.
// ----------------------------------------------------------------------------
module irlcf_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic                  kind_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            red_i,
  input  logic [7:0]            blue_i,
  input  logic [2:0]            attack_i,
  input  logic [2:0]            sustain_i,
  input  logic [2:0]            release_req_i,
  output logic                  frm_valid_o,
  input  logic                  frm_ready_i,
  output irlcf_pkg::frame_t     frm_o
);

  logic              s1_valid_q, s1_valid_d;
  irlcf_pkg::frame_t s1_q, s1_d;
  logic              accept;
  logic              env_on;
  logic [7:0]        sum;

  assign full_o = s1_valid_q & ~frm_ready_i;
  assign accept = push_i & ~full_o;
  assign env_on = (attack_i != 3'd0) | (sustain_i != 3'd0) | (release_req_i != 3'd0);

  always_comb begin
    s1_d          = '0;
    s1_d.rejected = ~kind_i & ((green_i[7:6] | red_i[7:6] | blue_i[7:6]) != 2'b00);
    if (kind_i) begin
      s1_d.sym[1] = irlcf_pkg::enc(irlcf_pkg::MOTION_MODE0);
      s1_d.sym[2] = irlcf_pkg::enc(irlcf_pkg::MOTION_MODE1);
      s1_d.sym[3] = irlcf_pkg::enc({attack_i, irlcf_pkg::MOTION_ATK_LOW});
      s1_d.sym[4] = irlcf_pkg::enc({release_req_i, sustain_i});
    end else begin
      s1_d.sym[1] = irlcf_pkg::enc(6'd0);
      s1_d.sym[2] = irlcf_pkg::enc(green_i[5:0]);
      s1_d.sym[3] = irlcf_pkg::enc(red_i[5:0]);
      s1_d.sym[4] = irlcf_pkg::enc(blue_i[5:0]);
      if (env_on) begin
        s1_d.long_frm = 1'b1;
        s1_d.sym[5]   = irlcf_pkg::enc({attack_i, 3'b000});
        s1_d.sym[6]   = irlcf_pkg::enc({release_req_i, sustain_i});
        s1_d.sym[7]   = irlcf_pkg::enc(6'd0);
      end
    end
  end

  assign s1_valid_d = accept | (s1_valid_q & ~frm_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  // Unused bytes were left at zero, so summing all of them is exact.
  always_comb begin
    sum = 8'd0;
    for (int i = 1; i < irlcf_pkg::FRAME_BYTES; i++) begin
      sum = sum + s1_q.sym[i];
    end
  end

  always_comb begin
    frm_o        = s1_q;
    frm_o.sym[0] = irlcf_pkg::enc(sum[7:2]);
  end

  assign frm_valid_o = s1_valid_q;

endmodule

// ===== rtl/irlcf_queue.sv =====
// ----------------------------------------------------------------------------
// IR light command framer frame queue
// Short first-in first-out queue of classified frames between the front
// end and the sequencer.
// ----------------------------------------------------------------------------
module irlcf_queue #(
  parameter int unsigned Depth = irlcf_pkg::FRAME_QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  irlcf_pkg::frame_t wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_pop_i,
  output irlcf_pkg::frame_t rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  irlcf_pkg::frame_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              wr_en, rd_en;

  assign wr_ready_o = (cnt_q != FullCnt);
  assign rd_valid_o = (cnt_q != '0);
  assign wr_en      = wr_valid_i & wr_ready_o;
  assign rd_en      = rd_pop_i & rd_valid_o;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== rtl/irlcf_back.sv =====
// ----------------------------------------------------------------------------
// IR light command framer sequencer
// Walks the head frame one result per cycle while the result buffer has room:
// preamble, checksum, payload, or one rejected result, into a two-entry result buffer that the consumer pops.
// ----------------------------------------------------------------------------
module irlcf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              frm_valid_i,
  output logic              frm_pop_o,
  input  irlcf_pkg::frame_t frm_i,
  output logic              empty_o,
  input  logic              pop_i,
  output irlcf_pkg::res_t   res_o
);

  logic [3:0]      idx_q, idx_d;
  logic [3:0]      idx_m1;
  logic [3:0]      last_idx;
  logic            emit;
  logic            is_last;
  irlcf_pkg::res_t res;

  irlcf_pkg::res_t obuf_q [2];
  logic            owr_q, ord_q;
  logic [1:0]      ocnt_q, ocnt_d;
  logic            obuf_space, obuf_rd;

  assign obuf_space = (ocnt_q != 2'd2);
  assign emit       = frm_valid_i & obuf_space;
  assign last_idx   = frm_i.long_frm ? irlcf_pkg::LONG_LAST_IDX : irlcf_pkg::SHORT_LAST_IDX;
  assign idx_m1     = idx_q - 4'd1;
  assign is_last    = frm_i.rejected | (idx_q == last_idx);
  assign frm_pop_o  = emit & is_last;

  always_comb begin
    res = '0;
    if (frm_i.rejected) begin
      res.rejected = 1'b1;
      res.last     = 1'b1;
    end else if (idx_q == 4'd0) begin
      res.is_preamble = 1'b1;
    end else begin
      res.symbol = frm_i.sym[idx_m1[2:0]];
      res.last   = is_last;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (emit) begin
      idx_d = is_last ? 4'd0 : idx_q + 4'd1;
    end
  end

  assign obuf_rd = pop_i & ~empty_o;
  assign empty_o = (ocnt_q == 2'd0);
  assign res_o   = obuf_q[ord_q];

  always_comb begin
    ocnt_d = ocnt_q;
    if (emit && !obuf_rd) begin
      ocnt_d = ocnt_q + 2'd1;
    end else if (obuf_rd && !emit) begin
      ocnt_d = ocnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= 4'd0;
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      idx_q  <= idx_d;
      ocnt_q <= ocnt_d;
      if (emit) begin
        owr_q <= ~owr_q;
      end
      if (obuf_rd) begin
        ord_q <= ~ord_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      obuf_q[owr_q] <= res;
    end
  end

endmodule

// ===== rtl/ir_light_command_framer_unit.sv =====
// ----------------------------------------------------------------------------
// IR light command framer
// Turns one light command into a frame of infrared symbol bytes.
// ----------------------------------------------------------------------------
// Input side looks like a queue: drive the command fields with push, and
// the command is taken at a clock edge where push is high and full low.
// Result side also looks like a queue: while empty is low the oldest
// result sits on symbol_o, is_preamble_o, rejected_o and last_o, and it is
// removed at an edge where pop is high.
// A valid command yields a preamble marker, the checksum byte and the
// payload bytes, 6 or 9 results; an out-of-range colour yields one rejected
// result. last_o flags the final result of each command.
// The command is held in the front register, moves into the frame queue,
// and its results are written from there to the result buffer.
// The sequencer gives one result per cycle while the result buffer has room;
// the front end and the frame queue let the next commands be taken meanwhile.
// Reset empties every stage; no state is kept between commands.
// When the consumer stops popping, the result buffer fills, the sequencer
// holds, and full rises once the frame queue and front register fill.
// ----------------------------------------------------------------------------
module ir_light_command_framer_unit #(
  parameter int unsigned QueueDepth = irlcf_pkg::FRAME_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       kind_i,
  input  logic [7:0] green_i,
  input  logic [7:0] red_i,
  input  logic [7:0] blue_i,
  input  logic [2:0] attack_i,
  input  logic [2:0] sustain_i,
  input  logic [2:0] release_req_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] symbol_o,
  output logic       is_preamble_o,
  output logic       rejected_o,
  output logic       last_o
);

  logic              f2q_valid, f2q_ready;
  irlcf_pkg::frame_t f2q_data;
  logic              q2b_valid, q2b_pop;
  irlcf_pkg::frame_t q2b_data;
  irlcf_pkg::res_t   res;

  irlcf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .kind_i        (kind_i),
    .green_i       (green_i),
    .red_i         (red_i),
    .blue_i        (blue_i),
    .attack_i      (attack_i),
    .sustain_i     (sustain_i),
    .release_req_i (release_req_i),
    .frm_valid_o   (f2q_valid),
    .frm_ready_i   (f2q_ready),
    .frm_o         (f2q_data)
  );

  irlcf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f2q_valid),
    .wr_ready_o (f2q_ready),
    .wr_data_i  (f2q_data),
    .rd_valid_o (q2b_valid),
    .rd_pop_i   (q2b_pop),
    .rd_data_o  (q2b_data)
  );

  irlcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frm_valid_i (q2b_valid),
    .frm_pop_o   (q2b_pop),
    .frm_i       (q2b_data),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign symbol_o      = res.symbol;
  assign is_preamble_o = res.is_preamble;
  assign rejected_o    = res.rejected;
  assign last_o        = res.last;

  // A rejected result is always the only, and so the final, result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rejected_o) |-> (last_o && !is_preamble_o && symbol_o == 8'd0))
    else $error("rejected result malformed");

  // A preamble opens a frame and is never its end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && is_preamble_o) |-> (!last_o && !rejected_o && symbol_o == 8'd0))
    else $error("preamble result malformed");

  // The front end only stalls when the frame queue refuses its frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> (f2q_valid && !f2q_ready))
    else $error("front end stalled without backpressure");

  // A frame leaves the queue only together with its last result, so the result buffer is not empty afterwards.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q2b_pop |=> (!empty))
    else $error("frame retired without a result");

endmodule
